FILE: hdl/assert_macros.svh
// assert_macros.svh: assertion macros shared by the vertex generator RTL.
// Depends on nothing; files that assert include it by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked assertion with an explicit clock and active-low reset.
`define HVG_ASSERT_ON(clk_s, rst_s, lbl, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error(msg);

// Assertion on the local clk and rst_n.
`define HVG_ASSERT(lbl, prop, msg) `HVG_ASSERT_ON(clk, rst_n, lbl, prop, msg)

`endif

FILE: hdl/hvg_pkg.sv
// hvg_pkg: widths, register indexes, command/status structs and the
// per-vertex corner table of the heightmap vertex generator. No dependencies.
`timescale 1ns / 1ps

package hvg_pkg;

  // Field widths
  localparam int GRID_W     = 9;
  localparam int TEX_W      = 17;
  localparam int PERIOD_W   = 9;
  localparam int SCALE_W    = 16;
  localparam int HS_W       = 8;
  localparam int CNT_W      = 8;
  localparam int Y_W        = 24;
  localparam int XZ_W       = 9;
  localparam int CFG_DATA_W = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int TPROD_W    = TEX_W + CNT_W;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TEX_STEP     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TEX_PERIOD   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_SCALE = 3'd4;

  // Item opcodes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_GEN  = 1'b1;

  localparam logic [TEX_W-1:0] ONE_Q16 = 17'h10000;

  // Sequencing limits
  localparam logic [2:0] VTX_LAST   = 3'd5;
  localparam logic [2:0] FETCH_LAST = 3'd4;

  // Corner pixel slots
  localparam logic [1:0] PIX_LD = 2'd0;
  localparam logic [1:0] PIX_LU = 2'd1;
  localparam logic [1:0] PIX_RU = 2'd2;
  localparam logic [1:0] PIX_RD = 2'd3;

  // dx selects the right column and u_r, dz the upper row and v_up
  typedef struct packed {
    logic [1:0] pix;
    logic       dx;
    logic       dz;
    logic       last;
  } vtx_info_t;

  typedef struct packed {
    logic       load_wr;
    logic       load_step;
    logic       mul;
    logic       addr;
    logic       rd_en;
    logic [1:0] rd_idx;
    logic       emit;
    logic [2:0] vidx;
    logic       advance;
  } hvg_cmd_t;

  typedef struct packed {
    logic out_free;
  } hvg_sts_t;

  // Vertex order: LL, UL, UR, LL, UR, LR
  function automatic vtx_info_t vtx_info(input logic [2:0] idx);
    vtx_info_t r;
    r = '0;
    case (idx)
      3'd0: r = '{pix: PIX_LD, dx: 1'b0, dz: 1'b0, last: 1'b0};
      3'd1: r = '{pix: PIX_LU, dx: 1'b0, dz: 1'b1, last: 1'b0};
      3'd2: r = '{pix: PIX_RU, dx: 1'b1, dz: 1'b1, last: 1'b0};
      3'd3: r = '{pix: PIX_LD, dx: 1'b0, dz: 1'b0, last: 1'b0};
      3'd4: r = '{pix: PIX_RU, dx: 1'b1, dz: 1'b1, last: 1'b0};
      3'd5: r = '{pix: PIX_RD, dx: 1'b1, dz: 1'b0, last: 1'b1};
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

FILE: hdl/hvg_cfg.sv
// hvg_cfg: configuration registers and grid-size saturation.
// Depends on hvg_pkg.
`timescale 1ns / 1ps

module hvg_cfg import hvg_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  localparam int EWW = $clog2(MAX_WIDTH + 1),
  localparam int EHW = $clog2(MAX_HEIGHT + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic [EWW-1:0]        eff_w,
  output logic [EHW-1:0]        eff_h,
  output logic [TEX_W-1:0]      tex_step,
  output logic [PERIOD_W-1:0]   tex_period,
  output logic [SCALE_W-1:0]    height_scale
);

  logic [GRID_W-1:0]   gw_r;
  logic [GRID_W-1:0]   gh_r;
  logic [TEX_W-1:0]    step_r;
  logic [PERIOD_W-1:0] period_r;
  logic [SCALE_W-1:0]  scale_r;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gw_r     <= 9'd256;
      gh_r     <= 9'd256;
      step_r   <= 17'd2048;
      period_r <= 9'd32;
      scale_r  <= 16'd6554;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GRID_WIDTH:   gw_r     <= cfg_data[GRID_W-1:0];
        REG_GRID_HEIGHT:  gh_r     <= cfg_data[GRID_W-1:0];
        REG_TEX_STEP:     step_r   <= cfg_data[TEX_W-1:0];
        REG_TEX_PERIOD:   period_r <= cfg_data[PERIOD_W-1:0];
        REG_HEIGHT_SCALE: scale_r  <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp grid size to 1..MAX
  always_comb begin
    if (gw_r == '0) begin
      eff_w = EWW'(1);
    end else if (32'(gw_r) > MAX_WIDTH) begin
      eff_w = EWW'(MAX_WIDTH);
    end else begin
      eff_w = EWW'(gw_r);
    end
    if (gh_r == '0) begin
      eff_h = EHW'(1);
    end else if (32'(gh_r) > MAX_HEIGHT) begin
      eff_h = EHW'(MAX_HEIGHT);
    end else begin
      eff_h = EHW'(gh_r);
    end
  end

  assign tex_step     = step_r;
  assign tex_period   = period_r;
  assign height_scale = scale_r;

endmodule

FILE: hdl/hvg_ctrl.sv
// hvg_ctrl: sequencer for load and generate items; drives datapath commands.
// Depends on hvg_pkg.
`timescale 1ns / 1ps

module hvg_ctrl import hvg_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_op,
  output logic     in_stall,
  input  hvg_sts_t sts,
  output hvg_cmd_t cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_LOAD  = 6'b000010,
    S_MUL   = 6'b000100,
    S_ADDR  = 6'b001000,
    S_FETCH = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic [2:0] vidx_r, vidx_nxt;
  logic       accept;

  assign in_stall = (state_r != S_IDLE) || !rst_n;
  assign accept   = in_valid && !in_stall;

  // Next state and commands
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    vidx_nxt   = vidx_r;
    cmd        = '0;
    cmd.rd_idx = cnt_r[1:0];
    cmd.vidx   = vidx_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_op == OP_GEN) begin
            state_nxt = S_MUL;
          end else begin
            cmd.load_wr = 1'b1;
            state_nxt   = S_LOAD;
          end
        end
      end
      S_LOAD: begin
        cmd.load_step = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_ADDR;
      end
      S_ADDR: begin
        cmd.addr  = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_FETCH;
      end
      S_FETCH: begin
        // reads in the first four steps, the last step drains the multiply
        cmd.rd_en = (cnt_r != FETCH_LAST);
        if (cnt_r == FETCH_LAST) begin
          vidx_nxt  = '0;
          state_nxt = S_EMIT;
        end else begin
          cnt_nxt = cnt_r + 3'd1;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (vidx_r == VTX_LAST) begin
            cmd.advance = 1'b1;
            state_nxt   = S_IDLE;
          end else begin
            vidx_nxt = vidx_r + 3'd1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      vidx_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      vidx_r  <= vidx_nxt;
    end
  end

endmodule

FILE: hdl/hvg_dp.sv
// hvg_dp: height store, cell/texture counters, address and texture math,
// height scaling and the output register. Depends on hvg_pkg.
`timescale 1ns / 1ps

module hvg_dp import hvg_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  localparam int EWW   = $clog2(MAX_WIDTH + 1),
  localparam int EHW   = $clog2(MAX_HEIGHT + 1),
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT,
  localparam int AW    = $clog2(DEPTH),
  localparam int NW    = $clog2(DEPTH + 1),
  localparam int CW    = $clog2(MAX_WIDTH),
  localparam int RW    = $clog2(MAX_HEIGHT)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  hvg_cmd_t            cmd,
  output hvg_sts_t            sts,
  input  logic [HS_W-1:0]     in_height_sample,
  input  logic [EWW-1:0]      eff_w,
  input  logic [EHW-1:0]      eff_h,
  input  logic [TEX_W-1:0]    tex_step,
  input  logic [PERIOD_W-1:0] tex_period,
  input  logic [SCALE_W-1:0]  height_scale,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [XZ_W-1:0]     out_pos_x,
  output logic [Y_W-1:0]      out_pos_y,
  output logic [XZ_W-1:0]     out_pos_z,
  output logic [TEX_W-1:0]    out_tex_u,
  output logic [TEX_W-1:0]    out_tex_v,
  output logic                out_last_of_cell,
  output logic                out_last_cell
);

  logic [HS_W-1:0]    mem [DEPTH];
  logic [HS_W-1:0]    mem_q_r;
  logic               rd_pend_r;
  logic [1:0]         rd_pidx_r;

  logic [AW-1:0]      la_r, la_nxt;
  logic [NW-1:0]      n_r;
  logic [CW-1:0]      col_r;
  logic [RW-1:0]      row_r;
  logic [CNT_W-1:0]   tcc_r;
  logic [CNT_W-1:0]   trc_r;

  logic [AW-1:0]      rb_r;
  logic [TPROD_W-1:0] ul_raw_r;
  logic [TPROD_W-1:0] vl_raw_r;
  logic [AW-1:0]      pix_r [4];
  logic [TEX_W-1:0]   ul_r, ur_r, vlo_r, vup_r;
  logic [Y_W-1:0]     y_r [4];

  logic [EWW+EHW-1:0] n_full;
  logic [RW+EWW-1:0]  rb_full;
  logic [31:0]        ld_a, rd_a, lu_a, ru_a, n32;
  logic [TPROD_W:0]   ul_f, ur_f, vl_f, vu_f;
  logic [TEX_W-1:0]   ul_nxt, ur_nxt, vlo_nxt, vup_nxt;
  logic               col_end, row_end;
  vtx_info_t          vi;
  logic [CW:0]        x_sum;
  logic [RW:0]        z_sum;
  logic               out_valid_r;

  // Texture counter step: wraps at the period and past 255
  function automatic logic [CNT_W-1:0] next_tex(input logic [CNT_W-1:0] c,
                                                input logic [PERIOD_W-1:0] p);
    logic [CNT_W:0] n;
    n = {1'b0, c} + (CNT_W + 1)'(1);
    if (32'(n) >= 32'(p) || n[CNT_W]) begin
      return '0;
    end
    return n[CNT_W-1:0];
  endfunction

  // Pixel count, free running off the config registers
  assign n_full  = eff_w * eff_h;
  assign rb_full = row_r * eff_w;

  // Grid edge tests
  assign col_end = (32'(col_r) + 32'd1) >= 32'(eff_w);
  assign row_end = (32'(row_r) + 32'd1) >= 32'(eff_h);

  // Load address wrap
  always_comb begin
    if ((32'(la_r) + 32'd1) >= 32'(n_r)) begin
      la_nxt = '0;
    end else begin
      la_nxt = AW'(32'(la_r) + 32'd1);
    end
  end

  // Corner addresses with clamping
  always_comb begin
    n32  = 32'(n_r);
    ld_a = 32'(rb_r) + 32'(col_r);
    rd_a = ld_a + 32'd1;
    if (rd_a >= n32) rd_a = n32 - 32'd1;
    lu_a = ld_a + 32'(eff_w);
    if (lu_a >= n32) lu_a = ld_a;
    ru_a = ld_a + 32'(eff_w) + 32'd1;
    if (ru_a >= n32) ru_a = rd_a;
  end

  // Texture coordinates, saturated to [0, 1.0]
  always_comb begin
    ul_f = {1'b0, ul_raw_r};
    ur_f = ul_f + (TPROD_W + 1)'(tex_step);
    vl_f = {1'b0, vl_raw_r};
    vu_f = vl_f + (TPROD_W + 1)'(tex_step);
    ul_nxt  = (ul_f > (TPROD_W + 1)'(ONE_Q16)) ? ONE_Q16 : TEX_W'(ul_f);
    ur_nxt  = (ur_f > (TPROD_W + 1)'(ONE_Q16)) ? ONE_Q16 : TEX_W'(ur_f);
    vlo_nxt = (vl_f > (TPROD_W + 1)'(ONE_Q16)) ? '0 : ONE_Q16 - TEX_W'(vl_f);
    vup_nxt = (vu_f > (TPROD_W + 1)'(ONE_Q16)) ? '0 : ONE_Q16 - TEX_W'(vu_f);
  end

  // Vertex corner selection
  assign vi    = vtx_info(cmd.vidx);
  assign x_sum = {1'b0, col_r} + (CW + 1)'(vi.dx);
  assign z_sum = {1'b0, row_r} + (RW + 1)'(vi.dz);

  // Height store: one write port for loads, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.load_wr) begin
      mem[la_r] <= in_height_sample;
    end
    if (cmd.rd_en) begin
      mem_q_r <= mem[pix_r[cmd.rd_idx]];
    end
  end

  // Control state: counters, read tracking, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      la_r        <= '0;
      col_r       <= '0;
      row_r       <= '0;
      tcc_r       <= '0;
      trc_r       <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_pend_r <= cmd.rd_en;
      if (cmd.load_step) begin
        la_r <= la_nxt;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      // advance to the next cell after its last vertex; restart after the final cell
      if (cmd.advance) begin
        if (col_end && row_end) begin
          col_r <= '0;
          row_r <= '0;
          tcc_r <= '0;
          trc_r <= '0;
        end else if (col_end) begin
          col_r <= '0;
          row_r <= row_r + RW'(1);
          tcc_r <= next_tex(tcc_r, tex_period);
          trc_r <= next_tex(trc_r, tex_period);
        end else begin
          col_r <= col_r + CW'(1);
          tcc_r <= next_tex(tcc_r, tex_period);
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    n_r       <= NW'(n_full);
    rd_pidx_r <= cmd.rd_idx;
    if (cmd.mul) begin
      rb_r     <= AW'(rb_full);
      ul_raw_r <= tex_step * tcc_r;
      vl_raw_r <= tex_step * trc_r;
    end
    if (cmd.addr) begin
      pix_r[PIX_LD] <= AW'(ld_a);
      pix_r[PIX_LU] <= AW'(lu_a);
      pix_r[PIX_RU] <= AW'(ru_a);
      pix_r[PIX_RD] <= AW'(rd_a);
      ul_r  <= ul_nxt;
      ur_r  <= ur_nxt;
      vlo_r <= vlo_nxt;
      vup_r <= vup_nxt;
    end
    if (rd_pend_r) begin
      y_r[rd_pidx_r] <= mem_q_r * height_scale;
    end
    if (cmd.emit) begin
      out_pos_x        <= XZ_W'(x_sum);
      out_pos_y        <= y_r[vi.pix];
      out_pos_z        <= XZ_W'(z_sum);
      out_tex_u        <= vi.dx ? ur_r : ul_r;
      out_tex_v        <= vi.dz ? vup_r : vlo_r;
      out_last_of_cell <= vi.last;
      out_last_cell    <= col_end && row_end;
    end
  end

  assign out_valid    = out_valid_r;
  assign sts.out_free = !out_valid_r || !out_stall;

endmodule

FILE: hdl/heightmap_terrain_vertex_generator.sv
// heightmap_terrain_vertex_generator: top level; depends on hvg_pkg, hvg_cfg,
// hvg_ctrl, hvg_dp and assert_macros.svh.
// Use: write grid_width, grid_height, tex_step, tex_period and height_scale
// on the cfg_ port while idle, then send load items (in_op = 0) carrying one
// height byte per pixel in raster order, then generate items (in_op = 1).
// Each generate item returns six vertices of the next cell on the out_
// channel (LL, UL, UR, LL, UR, LR); out_last_of_cell marks the sixth and
// out_last_cell marks all vertices of the final cell of the grid.
// Sequence: a load item writes its byte, then steps the load address. A
// generate item forms the row base and the texture products, then the
// corner addresses and texture coordinates, then makes four reads through
// the single read port of the height store plus scaling, then emits one
// vertex per cycle through the output register while out_ is not stalled.
// A stall on out_ holds the current vertex and pauses the vertex sequence;
// the next item is accepted while the last vertex still waits.
// Reset clears the config registers to their defaults, the load address and
// the cell/texture counters; the height store is not cleared.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module heightmap_terrain_vertex_generator import hvg_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_op,
  input  logic [HS_W-1:0]       in_height_sample,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [XZ_W-1:0]       out_pos_x,
  output logic [Y_W-1:0]        out_pos_y,
  output logic [XZ_W-1:0]       out_pos_z,
  output logic [TEX_W-1:0]      out_tex_u,
  output logic [TEX_W-1:0]      out_tex_v,
  output logic                  out_last_of_cell,
  output logic                  out_last_cell,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int EWW = $clog2(MAX_WIDTH + 1);
  localparam int EHW = $clog2(MAX_HEIGHT + 1);

  logic [EWW-1:0]      eff_w;
  logic [EHW-1:0]      eff_h;
  logic [TEX_W-1:0]    tex_step;
  logic [PERIOD_W-1:0] tex_period;
  logic [SCALE_W-1:0]  height_scale;
  hvg_cmd_t            cmd;
  hvg_sts_t            sts;

  hvg_cfg #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .eff_w        (eff_w),
    .eff_h        (eff_h),
    .tex_step     (tex_step),
    .tex_period   (tex_period),
    .height_scale (height_scale)
  );

  hvg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_op),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  hvg_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_height_sample (in_height_sample),
    .eff_w            (eff_w),
    .eff_h            (eff_h),
    .tex_step         (tex_step),
    .tex_period       (tex_period),
    .height_scale     (height_scale),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pos_x        (out_pos_x),
    .out_pos_y        (out_pos_y),
    .out_pos_z        (out_pos_z),
    .out_tex_u        (out_tex_u),
    .out_tex_v        (out_tex_v),
    .out_last_of_cell (out_last_of_cell),
    .out_last_cell    (out_last_cell)
  );

  // Checks
  `HVG_ASSERT(a_advance_on_last, cmd.advance |-> (cmd.emit && cmd.vidx == VTX_LAST), "cell advanced off the last vertex")
  `HVG_ASSERT(a_emit_when_free, cmd.emit |-> sts.out_free, "vertex emitted into a held output register")
  `HVG_ASSERT(a_load_steps, (in_valid && !in_stall && in_op == OP_LOAD) |=> cmd.load_step, "load item did not step the load address")

endmodule
